[rtl/core/bts_pkg.sv]
// Shared types and constants for the bilinear texture sampler.
// No dependencies.
package bts_pkg;

   localparam int COMP_W  = 16;
   localparam int NUM_CMP = 4;
   localparam int COORD_W = 24;
   localparam int DIM_W   = 7;
   localparam int FRAC_W  = 17;   // Q16 fraction, 0..65536

   typedef enum logic {
      FUNC_WRITE  = 1'b0,
      FUNC_SAMPLE = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      REG_WIDTH  = 3'd0,
      REG_HEIGHT = 3'd1,
      REG_COUNT  = 3'd2,
      REG_WRAP_U = 3'd3,
      REG_WRAP_V = 3'd4
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_ACC,
      ST_ROUND,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             clear;
      logic             accumulate;
      logic [FRAC_W:0]  unused;
   } lane_ctl_type;

endpackage

[rtl/core/bilinear_texture_sampler.sv]
// Bilinear texture sampler top level: memory, sequencer and four lanes.
// Depends on bts_pkg, bts_ram, bts_axis, bts_lane.
//
// Usage: req_ carries write or sample requests; rsp_ carries one filtered
// texel per sample request, none per write. csr_ writes the size, the
// component count and the wrap modes; the user must write them only while
// the block is idle, since the block does not enforce it. A write request
// goes straight to memory and leaves the block idle. A sample request reads
// four texels from the single-ported texture memory, one per cycle, and a
// lane per component multiplies and accumulates them; the sums are then
// rounded and held in an output register until rsp_tready, and while the
// result waits no request is accepted. req_tready returns the cycle after
// the result is handed off, so a new sample is not taken before then.
// Reset returns the registers to 64 x 64, four components, clamp on both
// axes. Memory contents are undefined until written.
module bilinear_texture_sampler #(
   parameter int MAX_TEXELS = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // texel_index, in_comp0..3, coord_u, coord_v (from bit 0), 4 pad bits
   input  logic [127:0] req_tdata,
   // func
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_comp0..out_comp3 from bit 0
   output logic [63:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [6:0]   csr_data
);
   localparam int AW = $clog2(MAX_TEXELS);

   bts_pkg::state_type state_ff, state_in;
   logic [6:0]  width_ff, height_ff;
   logic [2:0]  count_ff;
   logic        wrap_u_ff, wrap_v_ff;

   logic [11:0] req_index;
   logic [23:0] req_u, req_v;
   logic [63:0] req_comps;
   logic        accept;

   logic [5:0]  x0, x1, y0, y1;
   logic [16:0] dx, dy;
   logic [5:0]  x0_ff, x1_ff, y0_ff, y1_ff;
   logic [16:0] dx_ff, dy_ff;
   logic [1:0]  cnt_ff, cnt_in;
   logic        oob_ff, oob_in;
   logic        mac_ff, mac_in;

   logic [12:0] faddr;
   logic [AW-1:0] ram_addr;
   logic        ram_we;
   logic [63:0] ram_q;
   logic [33:0] weight;
   logic [16:0] wx, wy;
   bts_pkg::lane_ctl_type ctl;
   logic [15:0] lane_res [4];
   logic [63:0] out_ff, out_in;

   assign req_index = req_tdata[11:0];
   assign req_comps = req_tdata[75:12];
   assign req_u     = req_tdata[99:76];
   assign req_v     = req_tdata[123:100];
   assign req_tready = (state_ff == bts_pkg::ST_IDLE);
   assign accept    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'd64;
         height_ff <= 7'd64;
         count_ff  <= 3'd4;
         wrap_u_ff <= 1'b0;
         wrap_v_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bts_pkg::REG_WIDTH:  width_ff  <= (csr_data == 0) ? 7'd1 :
                                              (csr_data > 7'd64) ? 7'd64 : csr_data;
            bts_pkg::REG_HEIGHT: height_ff <= (csr_data == 0) ? 7'd1 :
                                              (csr_data > 7'd64) ? 7'd64 : csr_data;
            bts_pkg::REG_COUNT:  count_ff  <= (csr_data[2:0] == 0) ? 3'd1 :
                                              (csr_data[2:0] > 3'd4) ? 3'd4 : csr_data[2:0];
            bts_pkg::REG_WRAP_U: wrap_u_ff <= csr_data[0];
            bts_pkg::REG_WRAP_V: wrap_v_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   bts_axis u_axis_u (.coord(req_u), .wrap(wrap_u_ff), .size(width_ff),
                      .base(x0), .next(x1), .frac(dx));
   bts_axis u_axis_v (.coord(req_v), .wrap(wrap_v_ff), .size(height_ff),
                      .base(y0), .next(y1), .frac(dy));

   always_ff @(posedge clock) begin
      if (accept) begin
         x0_ff <= x0; x1_ff <= x1; y0_ff <= y0; y1_ff <= y1;
         dx_ff <= dx; dy_ff <= dy;
      end
   end

   // fetch order: (x0,y0) (x0,y1) (x1,y0) (x1,y1)
   always_comb begin
      faddr  = 13'(cnt_ff[0] ? y1_ff : y0_ff) * 13'(width_ff)
             + 13'(cnt_ff[1] ? x1_ff : x0_ff);
      oob_in = (32'(faddr) >= MAX_TEXELS);
      ram_we = accept && (req_tuser == bts_pkg::FUNC_WRITE) && (32'(req_index) < MAX_TEXELS);
      ram_addr = ram_we ? AW'(req_index) : AW'(faddr);
   end

   bts_ram #(.WIDTH(64), .DEPTH(MAX_TEXELS)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(req_comps), .rd_data(ram_q));

   // weight registered alongside the memory read of the same fetch
   always_comb begin
      wx = cnt_ff[1] ? dx_ff : 17'h10000 - dx_ff;
      wy = cnt_ff[0] ? dy_ff : 17'h10000 - dy_ff;
      weight = 34'(wx) * 34'(wy);
      mac_in = (state_ff == bts_pkg::ST_FETCH);
      ctl.clear = accept;
      ctl.accumulate = mac_ff;
      ctl.unused = '0;
   end

   always_ff @(posedge clock) begin
      oob_ff  <= oob_in;
      mac_ff  <= reset ? 1'b0 : mac_in;
   end

   logic [33:0] weight_ff;
   logic        mac2_ff;
   always_ff @(posedge clock) begin
      weight_ff <= weight;
      mac2_ff   <= reset ? 1'b0 : mac_ff;
   end

   bts_pkg::lane_ctl_type ctl2;
   always_comb begin
      ctl2 = ctl;
      ctl2.accumulate = mac2_ff;
   end

   for (genvar g = 0; g < 4; g++) begin : g_lane
      bts_lane u_lane (.clock(clock), .ctl(ctl2),
                       .texel(oob_ff ? 16'h0 : ram_q[16*g +: 16]),
                       .weight(weight_ff), .result(lane_res[g]));
   end

   // state machine
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         bts_pkg::ST_IDLE: begin
            cnt_in = 2'd0;
            if (accept && req_tuser == bts_pkg::FUNC_SAMPLE) begin
               state_in = bts_pkg::ST_FETCH;
            end
         end
         bts_pkg::ST_FETCH: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = bts_pkg::ST_ACC;
            end
         end
         bts_pkg::ST_ACC: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd2) begin
               state_in = bts_pkg::ST_ROUND;
            end
         end
         bts_pkg::ST_ROUND: state_in = bts_pkg::ST_OUT;
         bts_pkg::ST_OUT: begin
            if (rsp_tready) begin
               state_in = bts_pkg::ST_IDLE;
            end
         end
         default: state_in = bts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         out_in[16*i +: 16] = (3'(i) < count_ff) ? lane_res[i] : 16'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bts_pkg::ST_IDLE;
         cnt_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      if (state_ff == bts_pkg::ST_ROUND) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = (state_ff == bts_pkg::ST_OUT);
   assign rsp_tdata  = out_ff;
endmodule

[rtl/core/bts_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module bts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

[rtl/core/bts_axis.sv]
// Per-axis coordinate setup: base texel, neighbor and Q16 fraction.
// Depends on bts_pkg.
module bts_axis (
   input  logic [bts_pkg::COORD_W-1:0] coord,
   input  logic                        wrap,
   input  logic [bts_pkg::DIM_W-1:0]   size,
   output logic [5:0]                  base,
   output logic [5:0]                  next,
   output logic [bts_pkg::FRAC_W-1:0]  frac
);
   logic [16:0] f;
   logic [22:0] p;
   logic [6:0]  b;
   logic [6:0]  last;

   always_comb begin
      if (wrap) begin
         f = {1'b0, coord[15:0]};
      end else if (coord[23]) begin
         f = '0;
      end else if (coord > 24'h010000) begin
         f = 17'h10000;
      end else begin
         f = coord[16:0];
      end
      p    = 23'(size) * 23'(f);
      last = size - 7'd1;
      b    = p[22:16];
      if (b > last) begin
         b = last;
      end
      base = b[5:0];
      frac = 17'(p - {b, 16'h0});
      if (b + 7'd1 >= size) begin
         next = wrap ? 6'd0 : last[5:0];
      end else begin
         next = 6'(b + 7'd1);
      end
   end
endmodule

[rtl/core/bts_lane.sv]
// One component lane: multiply-accumulate of fetched texels by weights,
// then round and saturate. Depends on bts_pkg.
module bts_lane (
   input  logic                       clock,
   input  bts_pkg::lane_ctl_type      ctl,
   input  logic [bts_pkg::COMP_W-1:0] texel,
   input  logic [33:0]                weight,
   output logic [bts_pkg::COMP_W-1:0] result
);
   logic [49:0] prod_ff, prod_in;
   logic [51:0] acc_ff, acc_in;
   logic [51:0] r;

   always_comb begin
      prod_in = 50'(texel) * 50'(weight);
      acc_in  = ctl.clear ? '0 : (ctl.accumulate ? acc_ff + 52'(prod_ff) : acc_ff);
      r       = (acc_ff + 52'h80000000) >> 32;
      result  = (r > 52'hFFFF) ? 16'hFFFF : r[15:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end
endmodule
